// ===== rtl/core/rbd_pkg.sv =====
// ---------------------------------------------------------------------------
// rbd_pkg - shared types and constants for the retry backoff delay block
// Register map, strategy codes, stage payload structs and the Fibonacci table.
// ---------------------------------------------------------------------------
package rbd_pkg;

  // Register index, taken from paddr[4:2]
  typedef enum logic [2:0] {
    REG_STRATEGY      = 3'd0,
    REG_ATTEMPT_LIMIT = 3'd1,
    REG_BASE_DELAY    = 3'd2,
    REG_MIN_DELAY     = 3'd3,
    REG_MAX_DELAY     = 3'd4,
    REG_RETRY_ENABLE  = 3'd5
  } reg_idx_e;

  typedef enum logic [2:0] {
    STRAT_IMMEDIATE   = 3'd0,
    STRAT_FIXED       = 3'd1,
    STRAT_LINEAR      = 3'd2,
    STRAT_EXPONENTIAL = 3'd3,
    STRAT_FIBONACCI   = 3'd4
  } strategy_e;

  localparam int unsigned PADDR_W   = 5;
  localparam int unsigned SEC_W     = 16;   // seconds fields
  localparam int unsigned MUL_A_W   = 17;   // attempt factor: up to 2^15 or F(23)
  localparam int unsigned PROD_W    = MUL_A_W + SEC_W;
  localparam int unsigned MS_W      = 26;
  localparam int unsigned MS_PER_S  = 1000;
  localparam int unsigned MS_MAX    = 65535000;

  // From these attempt numbers on, any nonzero unit exceeds a 16-bit cap.
  localparam int unsigned EXP_SAT_ATTEMPT = 16;
  localparam int unsigned FIB_SAT_ATTEMPT = 24;

  typedef struct packed {
    logic [2:0]       strategy;
    logic [7:0]       attempt_limit;
    logic [SEC_W-1:0] base_delay_s;
    logic [SEC_W-1:0] min_delay_s;
    logic [SEC_W-1:0] max_delay_s;
    logic             retry_enable;
  } cfg_t;

  // Stage 1 payload: multiplier operands plus overflow flag
  typedef struct packed {
    logic [MUL_A_W-1:0] mul_a;
    logic [SEC_W-1:0]   mul_b;
    logic               sat;
    logic               retry_ok;
  } opnd_t;

  // Product stage payload
  typedef struct packed {
    logic [PROD_W-1:0] prod;
    logic              sat;
    logic              retry_ok;
  } prod_t;

  // Capped delay in seconds
  typedef struct packed {
    logic [SEC_W-1:0] delay_s;
    logic             retry_ok;
  } sec_t;

  // F(0) = F(1) = 1; only entries below FIB_SAT_ATTEMPT are ever needed
  function automatic logic [SEC_W-1:0] fib_lookup(input logic [4:0] idx);
    logic [SEC_W-1:0] f;
    case (idx)
      5'd0:    f = 16'd1;
      5'd1:    f = 16'd1;
      5'd2:    f = 16'd2;
      5'd3:    f = 16'd3;
      5'd4:    f = 16'd5;
      5'd5:    f = 16'd8;
      5'd6:    f = 16'd13;
      5'd7:    f = 16'd21;
      5'd8:    f = 16'd34;
      5'd9:    f = 16'd55;
      5'd10:   f = 16'd89;
      5'd11:   f = 16'd144;
      5'd12:   f = 16'd233;
      5'd13:   f = 16'd377;
      5'd14:   f = 16'd610;
      5'd15:   f = 16'd987;
      5'd16:   f = 16'd1597;
      5'd17:   f = 16'd2584;
      5'd18:   f = 16'd4181;
      5'd19:   f = 16'd6765;
      5'd20:   f = 16'd10946;
      5'd21:   f = 16'd17711;
      5'd22:   f = 16'd28657;
      5'd23:   f = 16'd46368;
      default: f = 16'd0;
    endcase
    return f;
  endfunction

endpackage

// ===== rtl/core/rbd_operand.sv =====
// ---------------------------------------------------------------------------
// rbd_operand - strategy decode stage
// Turns an attempt into multiplier operands in seconds and an overflow flag,
// and settles the retry decision.
// ---------------------------------------------------------------------------
module rbd_operand #(
  parameter int unsigned ATTEMPT_BITS = 8
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  rbd_pkg::cfg_t           cfg_i,
  input  logic                    valid_i,
  output logic                    stall_o,
  input  logic [ATTEMPT_BITS-1:0] delay_attempt_i,
  input  logic [7:0]              attempts_made_i,
  input  logic                    succeeded_i,
  output logic                    valid_o,
  input  logic                    stall_i,
  output rbd_pkg::opnd_t          data_o
);
  import rbd_pkg::*;

  // one extra bit so the saturation thresholds fit at the narrowest width
  localparam int unsigned ExtW = ATTEMPT_BITS + 1;

  logic [ExtW-1:0] att_ext;
  opnd_t           opnd_d, opnd_q;
  logic            valid_q;
  logic            exp_over, fib_over;

  assign att_ext  = ExtW'(delay_attempt_i);
  assign exp_over = att_ext >= ExtW'(EXP_SAT_ATTEMPT);
  assign fib_over = att_ext >= ExtW'(FIB_SAT_ATTEMPT);

  always_comb begin
    opnd_d.mul_a    = '0;
    opnd_d.mul_b    = '0;
    opnd_d.sat      = 1'b0;
    opnd_d.retry_ok = cfg_i.retry_enable && (attempts_made_i < cfg_i.attempt_limit) &&
                      !succeeded_i;
    if (cfg_i.retry_enable) begin
      case (strategy_e'(cfg_i.strategy))
        STRAT_FIXED: begin
          opnd_d.mul_a = MUL_A_W'(1);
          opnd_d.mul_b = cfg_i.base_delay_s;
        end
        STRAT_LINEAR: begin
          opnd_d.mul_a = MUL_A_W'(delay_attempt_i) + MUL_A_W'(1);
          opnd_d.mul_b = cfg_i.base_delay_s;
        end
        STRAT_EXPONENTIAL: begin
          opnd_d.mul_a = exp_over ? '0 : (MUL_A_W'(1) << att_ext[3:0]);
          opnd_d.mul_b = cfg_i.min_delay_s;
          opnd_d.sat   = exp_over && (cfg_i.min_delay_s != '0);
        end
        STRAT_FIBONACCI: begin
          opnd_d.mul_a = fib_over ? '0 : MUL_A_W'(fib_lookup(att_ext[4:0]));
          opnd_d.mul_b = cfg_i.min_delay_s;
          opnd_d.sat   = fib_over && (cfg_i.min_delay_s != '0);
        end
        default: begin
          opnd_d.mul_a = '0;  // immediate and unused codes
        end
      endcase
    end
  end

  assign stall_o = valid_q && stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (!stall_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && !stall_o) begin
      opnd_q <= opnd_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = opnd_q;

endmodule

// ===== rtl/core/rbd_scale.sv =====
// ---------------------------------------------------------------------------
// rbd_scale - multiply and cap stages
// Registered 17x16 product, then clamp to the maximum delay in seconds.
// ---------------------------------------------------------------------------
module rbd_scale (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic [15:0]            max_delay_s_i,
  input  logic                   valid_i,
  output logic                   stall_o,
  input  rbd_pkg::opnd_t         data_i,
  output logic                   valid_o,
  input  logic                   stall_i,
  output rbd_pkg::sec_t          data_o
);
  import rbd_pkg::*;

  prod_t prod_d, prod_q;
  sec_t  sec_d, sec_q;
  logic  prod_valid_q, sec_valid_q;
  logic  prod_stall, over;

  // multiply stage
  always_comb begin
    prod_d.prod     = PROD_W'(data_i.mul_a) * PROD_W'(data_i.mul_b);
    prod_d.sat      = data_i.sat;
    prod_d.retry_ok = data_i.retry_ok;
  end

  // cap stage
  assign over = prod_q.sat || (prod_q.prod > PROD_W'(max_delay_s_i));
  always_comb begin
    sec_d.delay_s  = over ? max_delay_s_i : prod_q.prod[SEC_W-1:0];
    sec_d.retry_ok = prod_q.retry_ok;
  end

  assign stall_o    = prod_valid_q && prod_stall;
  assign prod_stall = sec_valid_q && stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prod_valid_q <= 1'b0;
      sec_valid_q  <= 1'b0;
    end else begin
      if (!stall_o) begin
        prod_valid_q <= valid_i;
      end
      if (!prod_stall) begin
        sec_valid_q <= prod_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && !stall_o) begin
      prod_q <= prod_d;
    end
    if (prod_valid_q && !prod_stall) begin
      sec_q <= sec_d;
    end
  end

  assign valid_o = sec_valid_q;
  assign data_o  = sec_q;

endmodule

// ===== rtl/core/rbd_tomsec.sv =====
// ---------------------------------------------------------------------------
// rbd_tomsec - output stage
// Seconds to milliseconds; this register is the block's output register.
// ---------------------------------------------------------------------------
module rbd_tomsec (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   valid_i,
  output logic                   stall_o,
  input  rbd_pkg::sec_t          data_i,
  output logic                   valid_o,
  input  logic                   stall_i,
  output logic [25:0]            delay_ms_o,
  output logic                   retry_ok_o
);
  import rbd_pkg::*;

  logic            valid_q;
  logic [MS_W-1:0] delay_ms_d, delay_ms_q;
  logic            retry_ok_q;

  // 65535 * 1000 still fits 26 bits
  assign delay_ms_d = MS_W'(data_i.delay_s) * MS_W'(MS_PER_S);

  assign stall_o = valid_q && stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (!stall_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && !stall_o) begin
      delay_ms_q <= delay_ms_d;
      retry_ok_q <= data_i.retry_ok;
    end
  end

  assign valid_o    = valid_q;
  assign delay_ms_o = delay_ms_q;
  assign retry_ok_o = retry_ok_q;

endmodule

// ===== rtl/core/retry_backoff_delay.sv =====
// ---------------------------------------------------------------------------
// retry_backoff_delay - retry delay and retry decision generator
// Four-stage pipeline: decode, multiply, cap, convert to milliseconds.
// ---------------------------------------------------------------------------
// Usage notes
//   Input channel (valid_i / stall_o) carries one request per transfer:
//   delay_attempt_i, attempts_made_i, succeeded_i. Output channel
//   (valid_o / stall_i) carries one result per request: delay_ms_o and
//   retry_ok_o, in request order.
//   A transfer passes the decode, product, cap and ms registers to valid_o.
//   Throughput is one transfer per cycle unless the receiver stalls; the 17x16
//   seconds and 16x10 milliseconds multipliers each own a stage, which sets
//   the stage depth. Delays are computed in seconds, clamped to max_delay_s,
//   then scaled by 1000, so no stage ever needs more than a 33-bit product.
//   Each stage holds its data while the stage after it is full and stalled,
//   and takes new data otherwise, so bubbles close up under back pressure.
//   stall_o is raised only when every stage holds a transfer and the
//   receiver stalls. Nothing is dropped or repeated.
//   Reset clears all valid bits; the registers return to strategy
//   exponential, limit 3, base 2 s, unit 1 s, cap 60 s, retry enabled.
//   Registers are written over APB (byte address 4 * index); the user must
//   write them only while the pipeline is empty, the block does not enforce it.
// ---------------------------------------------------------------------------
module retry_backoff_delay #(
  parameter int unsigned ATTEMPT_BITS = 8
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  // APB configuration port
  input  logic                    psel,
  input  logic                    penable,
  input  logic                    pwrite,
  input  logic [4:0]              paddr,
  input  logic [31:0]             pwdata,
  output logic [31:0]             prdata,
  output logic                    pready,
  // request channel
  input  logic                    valid_i,
  output logic                    stall_o,
  input  logic [ATTEMPT_BITS-1:0] delay_attempt_i,
  input  logic [7:0]              attempts_made_i,
  input  logic                    succeeded_i,
  // result channel
  output logic                    valid_o,
  input  logic                    stall_i,
  output logic [25:0]             delay_ms_o,
  output logic                    retry_ok_o
);
  import rbd_pkg::*;

  cfg_t     cfg_q;
  reg_idx_e reg_idx;
  logic     cfg_wr;

  opnd_t    opnd;
  logic     opnd_valid, opnd_stall;
  sec_t     sec;
  logic     sec_valid, sec_stall;

  // ---------------- configuration registers ----------------
  assign pready  = 1'b1;
  assign reg_idx = reg_idx_e'(paddr[4:2]);
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.strategy      <= STRAT_EXPONENTIAL;
      cfg_q.attempt_limit <= 8'd3;
      cfg_q.base_delay_s  <= 16'd2;
      cfg_q.min_delay_s   <= 16'd1;
      cfg_q.max_delay_s   <= 16'd60;
      cfg_q.retry_enable  <= 1'b1;
    end else if (cfg_wr) begin
      case (reg_idx)
        REG_STRATEGY:      cfg_q.strategy      <= pwdata[2:0];
        REG_ATTEMPT_LIMIT: cfg_q.attempt_limit <= pwdata[7:0];
        REG_BASE_DELAY:    cfg_q.base_delay_s  <= pwdata[15:0];
        REG_MIN_DELAY:     cfg_q.min_delay_s   <= pwdata[15:0];
        REG_MAX_DELAY:     cfg_q.max_delay_s   <= pwdata[15:0];
        REG_RETRY_ENABLE:  cfg_q.retry_enable  <= pwdata[0];
        default: ;  // addresses past the map are ignored
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_STRATEGY:      prdata = 32'(cfg_q.strategy);
      REG_ATTEMPT_LIMIT: prdata = 32'(cfg_q.attempt_limit);
      REG_BASE_DELAY:    prdata = 32'(cfg_q.base_delay_s);
      REG_MIN_DELAY:     prdata = 32'(cfg_q.min_delay_s);
      REG_MAX_DELAY:     prdata = 32'(cfg_q.max_delay_s);
      REG_RETRY_ENABLE:  prdata = 32'(cfg_q.retry_enable);
      default:           prdata = '0;
    endcase
  end

  // ---------------- pipeline ----------------
  // stage 1: strategy decode, retry decision
  rbd_operand #(
    .ATTEMPT_BITS(ATTEMPT_BITS)
  ) u_operand (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_i          (cfg_q),
    .valid_i        (valid_i),
    .stall_o        (stall_o),
    .delay_attempt_i(delay_attempt_i),
    .attempts_made_i(attempts_made_i),
    .succeeded_i    (succeeded_i),
    .valid_o        (opnd_valid),
    .stall_i        (opnd_stall),
    .data_o         (opnd)
  );

  // stages 2 and 3: product in seconds, clamp to cap
  rbd_scale u_scale (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .max_delay_s_i(cfg_q.max_delay_s),
    .valid_i      (opnd_valid),
    .stall_o      (opnd_stall),
    .data_i       (opnd),
    .valid_o      (sec_valid),
    .stall_i      (sec_stall),
    .data_o       (sec)
  );

  // stage 4: milliseconds, output register
  rbd_tomsec u_tomsec (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .valid_i   (sec_valid),
    .stall_o   (sec_stall),
    .data_i    (sec),
    .valid_o   (valid_o),
    .stall_i   (stall_i),
    .delay_ms_o(delay_ms_o),
    .retry_ok_o(retry_ok_o)
  );

  // ---------------- assertions ----------------
  // an accepted request always lands in the first stage
  a_accept_lands: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_i && !stall_o) |=> opnd_valid)
    else $error("accepted request lost at stage 1");

  // back pressure reaches the input only with a full pipe and a stalled receiver
  a_stall_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    stall_o |-> (valid_o && stall_i && sec_valid && opnd_valid))
    else $error("input stalled without a full pipeline");

  // the millisecond result never exceeds the largest possible cap
  a_delay_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> (delay_ms_o <= MS_W'(MS_MAX)))
    else $error("delay out of range");

endmodule

// ===== sim/tb_top.sv =====
// ---------------------------------------------------------------------------
// tb_top - self-checking testbench for retry_backoff_delay
// Sends retry requests through the valid/stall request channel and checks
// every result against a local predictor of the delay and the retry
// decision. It covers the register settings, random idling on both sides
// and a long receiver hold-off that fills the pipeline.
// ---------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import rbd_pkg::*;

  localparam int unsigned ATTEMPT_W   = 8;
  localparam int unsigned IDLE_PCT    = 12;    // idle/stall chance per cycle
  localparam int unsigned HOLD_CYCLES = 80;    // receiver hold-off length
  localparam int unsigned DRAIN_WAIT  = 8;     // pipeline is 4 deep
  localparam int unsigned STALL_LIMIT = 1000;  // cycles without any transfer
  localparam int unsigned SHOW_MAX    = 10;    // mismatches printed in full
  localparam int unsigned RAND_PHASES = 12;
  localparam int unsigned PHASE_ITEMS = 100;
  // exponential: from this attempt on the C-level shift is treated as capped
  localparam int unsigned EXP_CAP_SHIFT = 27;
  // Fibonacci: every attempt past this one reuses its term
  localparam int unsigned FIB_END = 39;
  // register indexes past the end of the map; writes there are dropped
  localparam logic [2:0] REG_SPARE_LO = 3'd6;
  localparam logic [2:0] REG_SPARE_HI = 3'd7;

  typedef struct packed {
    logic [25:0] delay_ms;
    logic        retry_ok;
  } backoff_result_t;

  // -------------------------------------------------------------------------
  // Clock and DUT signals; every input is known from time zero
  // -------------------------------------------------------------------------
  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 psel = 1'b0;
  logic                 penable = 1'b0;
  logic                 pwrite = 1'b0;
  logic [4:0]           paddr = '0;
  logic [31:0]          pwdata = '0;
  logic [31:0]          prdata;
  logic                 pready;
  logic                 valid_i = 1'b0;
  logic                 stall_o;
  logic [ATTEMPT_W-1:0] delay_attempt_i = '0;
  logic [7:0]           attempts_made_i = '0;
  logic                 succeeded_i = 1'b0;
  logic                 valid_o;
  logic                 stall_i = 1'b0;
  logic [25:0]          delay_ms_o;
  logic                 retry_ok_o;

  initial begin
    forever #6 clk_i = ~clk_i;
  end

  retry_backoff_delay #(
    .ATTEMPT_BITS(ATTEMPT_W)
  ) i_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready),
    .valid_i        (valid_i),
    .stall_o        (stall_o),
    .delay_attempt_i(delay_attempt_i),
    .attempts_made_i(attempts_made_i),
    .succeeded_i    (succeeded_i),
    .valid_o        (valid_o),
    .stall_i        (stall_i),
    .delay_ms_o     (delay_ms_o),
    .retry_ok_o     (retry_ok_o)
  );

  // -------------------------------------------------------------------------
  // Scoreboard state
  // -------------------------------------------------------------------------
  cfg_t            shadow_cfg;        // mirror of the register file
  backoff_result_t due_results[$];    // expected results, oldest first
  int unsigned     mismatch_cnt = 0;
  int unsigned     fail_cnt = 0;
  bit              idle_en = 1'b1;    // random gaps/stalls on both sides
  int unsigned     hold_trigger = 0;  // bumped by a test to request a hold-off
  int unsigned     hold_seen = 0;
  int unsigned     hold_left = 0;
  int unsigned     quiet_cycles = 0;

  // -------------------------------------------------------------------------
  // Predictor: delay in ms computed at 64 bits, then capped at max * 1000.
  // Nothing wraps, so the cap is the only limit on the result.
  // -------------------------------------------------------------------------
  function automatic backoff_result_t backoff_predict(
    input logic [ATTEMPT_W-1:0] attempt,
    input logic [7:0]           made,
    input logic                 done
  );
    backoff_result_t  r;
    longint unsigned  cap;
    longint unsigned  raw;
    longint unsigned  fib_prev;
    longint unsigned  fib_cur;
    longint unsigned  fib_next;
    int unsigned      fib_idx;

    r = '0;
    if (!shadow_cfg.retry_enable) return r;
    cap = longint'(shadow_cfg.max_delay_s) * 1000;
    raw = 0;
    case (shadow_cfg.strategy)
      STRAT_FIXED:  raw = longint'(shadow_cfg.base_delay_s) * 1000;
      STRAT_LINEAR: raw = (longint'(attempt) + 1) * longint'(shadow_cfg.base_delay_s) * 1000;
      STRAT_EXPONENTIAL: begin
        if (shadow_cfg.min_delay_s == '0) raw = 0;
        else if (attempt >= EXP_CAP_SHIFT) raw = cap;
        else raw = (longint'(shadow_cfg.min_delay_s) << attempt) * 1000;
      end
      STRAT_FIBONACCI: begin
        // F(0) = F(1) = 1, walked up to the attempt, clipped at the table end
        fib_idx  = (attempt < FIB_END) ? attempt : FIB_END;
        fib_prev = 1;
        fib_cur  = 1;
        for (int unsigned n = 2; n <= fib_idx; n++) begin
          fib_next = fib_prev + fib_cur;
          fib_prev = fib_cur;
          fib_cur  = fib_next;
        end
        raw = fib_cur * longint'(shadow_cfg.min_delay_s) * 1000;
      end
      default: raw = 0;
    endcase
    r.delay_ms = (raw < cap) ? raw[25:0] : cap[25:0];
    r.retry_ok = (made < shadow_cfg.attempt_limit) && !done;
    return r;
  endfunction

  // -------------------------------------------------------------------------
  // APB register write: setup cycle, access cycle until pready, idle cycle
  // -------------------------------------------------------------------------
  task automatic reg_write(input logic [2:0] idx, input logic [31:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (pready !== 1'b1);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk_i);
    // mirror the write, masked to each field's width
    case (idx)
      REG_STRATEGY:      shadow_cfg.strategy      = data[2:0];
      REG_ATTEMPT_LIMIT: shadow_cfg.attempt_limit = data[7:0];
      REG_BASE_DELAY:    shadow_cfg.base_delay_s  = data[SEC_W-1:0];
      REG_MIN_DELAY:     shadow_cfg.min_delay_s   = data[SEC_W-1:0];
      REG_MAX_DELAY:     shadow_cfg.max_delay_s   = data[SEC_W-1:0];
      REG_RETRY_ENABLE:  shadow_cfg.retry_enable  = data[0];
      default: ;
    endcase
  endtask

  // Writes all six registers; junk in the upper bits must be masked off
  task automatic load_registers(input logic [2:0] strat, input logic [7:0] limit,
                                input logic [15:0] base, input logic [15:0] unit,
                                input logic [15:0] cap, input logic enable);
    reg_write(REG_STRATEGY,      {29'($urandom()), strat});
    reg_write(REG_ATTEMPT_LIMIT, {24'($urandom()), limit});
    reg_write(REG_BASE_DELAY,    {16'($urandom()), base});
    reg_write(REG_MIN_DELAY,     {16'($urandom()), unit});
    reg_write(REG_MAX_DELAY,     {16'($urandom()), cap});
    reg_write(REG_RETRY_ENABLE,  {31'($urandom()), enable});
  endtask

  // -------------------------------------------------------------------------
  // One request transfer, with an optional random gap in front of it.
  // valid_i stays high from one transfer to the next unless a gap is taken.
  // -------------------------------------------------------------------------
  task automatic send_request(input logic [ATTEMPT_W-1:0] attempt,
                              input logic [7:0] made, input logic done);
    while (idle_en && ($urandom_range(0, 99) < IDLE_PCT)) begin
      valid_i <= 1'b0;
      @(posedge clk_i);
    end
    valid_i         <= 1'b1;
    delay_attempt_i <= attempt;
    attempts_made_i <= made;
    succeeded_i     <= done;
    do @(posedge clk_i); while (stall_o !== 1'b0);
    due_results.insert(due_results.size(), backoff_predict(attempt, made, done));
  endtask

  // Drop valid, wait for every expected result, then let the pipe settle
  task automatic drain_pipeline();
    valid_i <= 1'b0;
    while (due_results.size() != 0) @(posedge clk_i);
    repeat (DRAIN_WAIT) @(posedge clk_i);
  endtask

  // Seconds value: mostly small, with the extremes mixed in
  function automatic logic [15:0] pick_seconds();
    case ($urandom_range(0, 5))
      0:       return 16'd0;
      1:       return 16'hFFFF;
      2:       return 16'($urandom());
      default: return 16'($urandom_range(1, 20));
    endcase
  endfunction

  // -------------------------------------------------------------------------
  // Receiver: random stalls, plus a long hold-off when a test asks for one
  // -------------------------------------------------------------------------
  always @(posedge clk_i) begin
    if (hold_seen != hold_trigger) begin
      hold_seen <= hold_trigger;
      hold_left <= HOLD_CYCLES;
      stall_i   <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      stall_i   <= 1'b1;
    end else begin
      stall_i <= idle_en && ($urandom_range(0, 99) < IDLE_PCT);
    end
  end

  // -------------------------------------------------------------------------
  // Result checker: every result transfer against the oldest expectation
  // -------------------------------------------------------------------------
  always @(posedge clk_i) begin
    backoff_result_t want;
    if (rst_ni && valid_o === 1'b1 && stall_i === 1'b0) begin
      if (due_results.size() == 0) begin
        fail_cnt++;
        if (mismatch_cnt < SHOW_MAX)
          $display("ERROR: result with none expected, delay_ms=%0d retry_ok=%0b",
                   delay_ms_o, retry_ok_o);
        mismatch_cnt++;
      end else begin
        want = due_results.pop_front();
        if (delay_ms_o !== want.delay_ms) begin
          fail_cnt++;
          if (mismatch_cnt < SHOW_MAX)
            $display("ERROR: delay_ms expected %0d, got %0d", want.delay_ms, delay_ms_o);
          mismatch_cnt++;
        end
        if (retry_ok_o !== want.retry_ok) begin
          fail_cnt++;
          if (mismatch_cnt < SHOW_MAX)
            $display("ERROR: retry_ok expected %0b, got %0b", want.retry_ok, retry_ok_o);
          mismatch_cnt++;
        end
      end
    end
  end

  // -------------------------------------------------------------------------
  // Watchdog: any transfer or register access counts as progress
  // -------------------------------------------------------------------------
  always @(posedge clk_i) begin
    if ((valid_i && !stall_o) || (valid_o && !stall_i) || (psel && penable))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("ERROR: no transfer for %0d cycles", STALL_LIMIT);
      $display("retry_backoff_delay test failed");
      $finish;
    end
  end

  // -------------------------------------------------------------------------
  // Tests
  // -------------------------------------------------------------------------

  // Reset values: exponential, limit 3, unit 1 s, cap 60 s, retry on
  task automatic test_reset_values();
    send_request(8'd0, 8'd0, 1'b0);
    send_request(8'd1, 8'd2, 1'b0);
    send_request(8'd5, 8'd3, 1'b0);   // 32 s, limit reached
    send_request(8'd6, 8'd2, 1'b1);   // capped at 60 s, already succeeded
    send_request(8'hFF, 8'hFF, 1'b0);
    drain_pipeline();
  endtask

  // Every strategy code, spare ones included, at both attempt extremes
  task automatic test_each_strategy();
    for (int s = 0; s < 8; s++) begin
      load_registers(3'(s), 8'd200, 16'd7, 16'd3, 16'hFFFF, 1'b1);
      send_request(8'd0, 8'd0, 1'b0);
      send_request(8'hFF, 8'hFF, 1'b0);
      drain_pipeline();
    end
  endtask

  // Retry disabled, zero cap, and writes past the end of the register map
  task automatic test_special_settings();
    load_registers(STRAT_FIXED, 8'd10, 16'd5, 16'd1, 16'd100, 1'b0);
    send_request(8'd3, 8'd0, 1'b0);
    drain_pipeline();
    load_registers(STRAT_FIBONACCI, 8'd10, 16'd5, 16'd4, 16'd0, 1'b1);
    send_request(8'd12, 8'd1, 1'b0);
    drain_pipeline();
    // spare indexes must leave the linear setting untouched
    load_registers(STRAT_LINEAR, 8'd10, 16'd9, 16'd4, 16'd5000, 1'b1);
    reg_write(REG_SPARE_LO, 32'hFFFF_FFFF);
    reg_write(REG_SPARE_HI, 32'h0000_0000);
    send_request(8'd40, 8'd9, 1'b0);
    drain_pipeline();
  endtask

  // Random phases, each with its own register setting; phase 0 and 1 take
  // the extremes, one phase runs with no idling at all
  task automatic test_random_traffic();
    logic [ATTEMPT_W-1:0] attempt;
    logic [7:0]           made;
    logic [2:0]           strat;
    for (int p = 0; p < RAND_PHASES; p++) begin
      if (p == 0)
        load_registers(STRAT_LINEAR, 8'hFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1);
      else if (p == 1)
        load_registers(STRAT_IMMEDIATE, 8'h00, 16'h0000, 16'h0000, 16'h0000, 1'b1);
      else begin
        strat = ($urandom_range(0, 9) < 8) ? 3'($urandom_range(0, 4))
                                           : 3'($urandom_range(5, 7));
        load_registers(strat, 8'($urandom()), pick_seconds(), pick_seconds(),
                       pick_seconds(), $urandom_range(0, 3) != 0);
      end
      idle_en = (p != 4);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        // small attempts hit the interesting part of the curves
        attempt = ($urandom_range(0, 9) < 7) ? ATTEMPT_W'($urandom_range(0, 45))
                                             : ATTEMPT_W'($urandom());
        // counts near the limit exercise the retry decision edge
        made = ($urandom_range(0, 9) < 6)
               ? 8'(shadow_cfg.attempt_limit + $urandom_range(0, 4) - 2)
               : 8'($urandom());
        send_request(attempt, made, $urandom_range(0, 3) == 0);
      end
      drain_pipeline();
      idle_en = 1'b1;
    end
  endtask

  // Receiver holds off for a long stretch while the sender keeps offering,
  // so the pipeline fills and stall_o has to rise
  task automatic test_receiver_hold();
    load_registers(STRAT_EXPONENTIAL, 8'd5, 16'd2, 16'd3, 16'd1000, 1'b1);
    idle_en = 1'b0;
    hold_trigger++;
    for (int n = 0; n < 40; n++)
      send_request(ATTEMPT_W'($urandom_range(0, 20)), 8'($urandom_range(0, 8)),
                   $urandom_range(0, 3) == 0);
    drain_pipeline();
    idle_en = 1'b1;
  endtask

  // -------------------------------------------------------------------------
  // Main sequence
  // -------------------------------------------------------------------------
  initial begin
    shadow_cfg = '{strategy: STRAT_EXPONENTIAL, attempt_limit: 8'd3,
                   base_delay_s: 16'd2, min_delay_s: 16'd1,
                   max_delay_s: 16'd60, retry_enable: 1'b1};
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_reset_values();
    test_each_strategy();
    test_special_settings();
    test_random_traffic();
    test_receiver_hold();

    if (due_results.size() != 0) begin
      fail_cnt++;
      $display("ERROR: %0d expected results never arrived", due_results.size());
    end
    if (fail_cnt == 0) begin
      $display("retry_backoff_delay test passed");
    end else begin
      $display("retry_backoff_delay test failed");
    end
    $finish;
  end

endmodule
